// File: hdl/lcdws_pkg.sv
// Shared types, codes and constants of the character LCD write sequencer.
package lcdws_pkg;

  localparam int LCDWS_MAX_DIGITS = 10;

  // Request codes carried by the mode field.
  localparam logic [1:0] MODE_CMD    = 2'd0;
  localparam logic [1:0] MODE_DATA   = 2'd1;
  localparam logic [1:0] MODE_INIT   = 2'd2;
  localparam logic [1:0] MODE_NUMBER = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FOUR_BIT_BUS  = 2'd0;
  localparam logic [1:0] CFG_ENABLE_HOLD   = 2'd1;
  localparam logic [1:0] CFG_POWER_UP_WAIT = 2'd2;

  localparam logic        FOUR_BIT_BUS_RESET  = 1'b0;
  localparam logic [7:0]  ENABLE_HOLD_RESET   = 8'd2;
  localparam logic [15:0] POWER_UP_WAIT_RESET = 16'd40;

  // Controller command bytes and character codes.
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] WAKE_NIBBLE      = 8'h20;
  localparam logic [7:0] ASCII_ZERO       = 8'h30;

  // Reciprocal of ten: floor(x / 10) = (x * DIV10_RECIP) >> DIV10_SHIFT for any 32-bit x.
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_WAIT,
    ST_WAKE,
    ST_BYTE
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dig_stat_t;

  // Initialisation command chosen by the number of bytes still to send.
  function automatic logic [7:0] init_cmd(input logic [1:0] remaining);
    logic [7:0] cmd;
    case (remaining)
      2'd3:    cmd = CMD_FUNCTION_SET;
      2'd2:    cmd = CMD_DISPLAY_ON;
      default: cmd = CMD_CLEAR;
    endcase
    return cmd;
  endfunction

endpackage

// File: hdl/lcdws_div10.sv
// Registered divide-by-ten unit giving quotient and remainder in the cycle after a request.
module lcdws_div10 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] dividend,
  output logic        valid,
  output logic [31:0] quotient,
  output logic [3:0]  remainder
);
  import lcdws_pkg::*;

  logic [63:0] prod;
  logic [31:0] x_r;
  logic [31:0] q_r;
  logic        valid_r;
  logic [3:0]  q10_lo;

  assign prod = 64'(dividend) * 64'(DIV10_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x_r <= dividend;
      q_r <= 32'(prod[63:DIV10_SHIFT]);
    end
  end

  // The remainder is below ten, so the low four bits of x - 10q are enough.
  assign q10_lo    = {q_r[0], 3'b000} + {q_r[2:0], 1'b0};
  assign remainder = x_r[3:0] - q10_lo;
  assign quotient  = q_r;
  assign valid     = valid_r;

endmodule

// File: hdl/lcdws_digits.sv
// Decimal digit extraction loop around the divide-by-ten unit, with the digit store.
module lcdws_digits #(
  parameter int   MAX_DIGITS = lcdws_pkg::LCDWS_MAX_DIGITS,
  localparam int  CNT_W = $clog2(((MAX_DIGITS > 3) ? MAX_DIGITS : 3) + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [31:0]          value,
  input  logic [CNT_W-1:0]     rd_pos,
  output logic [3:0]           rd_digit,
  output logic [CNT_W-1:0]     count,
  output lcdws_pkg::dig_stat_t stat
);
  import lcdws_pkg::*;

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic             busy_r;
  logic             done_r;
  logic             pend_r;
  logic [31:0]      work_r;
  logic [CNT_W-1:0] cnt_r;
  logic [3:0]       digit_r [MAX_DIGITS];
  logic             go;
  logic             div_valid;
  logic [31:0]      div_q;
  logic [3:0]       div_rem;
  logic             finish;
  logic [CNT_W-1:0] rd_sel;

  assign go     = busy_r && !pend_r;
  assign finish = div_valid && ((div_q == 32'd0) || (cnt_r == CNT_W'(MAX_DIGITS - 1)));

  lcdws_div10 u_div10 (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .dividend  (work_r),
    .valid     (div_valid),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pend_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      pend_r <= go;
      done_r <= finish;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (div_valid) begin
        cnt_r <= cnt_r + 1'b1;
        if (finish) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= value;
    end else if (div_valid) begin
      work_r <= div_q;
    end
    if (div_valid) begin
      digit_r[cnt_r[IDX_W-1:0]] <= div_rem;
    end
  end

  // Digits are stored least significant first; rd_pos counts down from count to one.
  assign rd_sel    = rd_pos - 1'b1;
  assign rd_digit  = digit_r[rd_sel[IDX_W-1:0]];
  assign count     = cnt_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  a_done_count : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (cnt_r != '0))
    else $error("digit conversion finished with no digits");

  a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("digit conversion still busy after completion");

endmodule

// File: hdl/char_lcd_write_sequencer_unit.sv
// Top level of the character LCD write sequencer: request sequencer and output register.
// Each pin state leaves as one beat; with out_ready held high one beat leaves per cycle
// (a command or data byte gives 2 beats on an 8-bit bus and 4 on a 4-bit bus, initialisation
// 7 or 15). A printed number first runs through the divide-by-ten unit one digit at a time,
// then gives 2 or 4 beats per digit.
// Reset is synchronous and active low: it empties the output register, returns the
// sequencer to idle and restores the configuration registers (8-bit bus, hold 2, wait 40).
module char_lcd_write_sequencer_unit #(
  parameter int  MAX_DIGITS = lcdws_pkg::LCDWS_MAX_DIGITS,
  localparam int CNT_W = $clog2(((MAX_DIGITS > 3) ? MAX_DIGITS : 3) + 1)
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_byte_value,
  input  logic [31:0] in_number_value,
  // Pin state channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_reg_select,
  output logic        out_read_write,
  output logic [7:0]  out_bus_value,
  output logic        out_enable_level,
  output logic [15:0] out_hold_units,
  output logic        out_last,
  // Configuration write port.
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lcdws_pkg::*;

  // Configuration registers.
  logic        four_bit_bus_r;
  logic [7:0]  enable_hold_r;
  logic [15:0] power_up_wait_r;

  // Sequencer state. The sequencer walks a request as a list of bytes (byte_cnt_r still to
  // go), each byte as one or two nibbles (nib_r) and each nibble as an enable pulse of two
  // pin states, enable high then enable low (ph_r).
  seq_state_t       state_r, state_nxt;
  logic [1:0]       mode_r;
  logic [7:0]       byte_r;
  logic [CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic             nib_r, nib_nxt;
  logic             ph_r, ph_nxt;

  // Output register holding each pin state; the sequencer stalls while it is full and not taken.
  logic        out_valid_r;
  logic        out_reg_select_r;
  logic [7:0]  out_bus_value_r;
  logic        out_enable_level_r;
  logic [15:0] out_hold_units_r;
  logic        out_last_r;

  logic             in_fire;
  logic             slot_free;
  logic             emitting;
  logic             fire;
  logic             dig_start;
  logic [3:0]       dig_digit;
  logic [CNT_W-1:0] dig_count;
  dig_stat_t        dig_stat;
  logic [7:0]       cur_byte;
  logic             cur_rs;
  logic             byte_done;
  logic             beat_rs;
  logic [7:0]       beat_bus;
  logic             beat_en;
  logic [15:0]      beat_hold;
  logic             beat_last;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign emitting  = (state_r == ST_WAIT) || (state_r == ST_WAKE) || (state_r == ST_BYTE);
  assign fire      = emitting && slot_free;
  assign dig_start = in_fire && (in_mode == MODE_NUMBER);

  lcdws_digits #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_digits (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dig_start),
    .value    (in_number_value),
    .rd_pos   (byte_cnt_r),
    .rd_digit (dig_digit),
    .count    (dig_count),
    .stat     (dig_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_bit_bus_r  <= FOUR_BIT_BUS_RESET;
      enable_hold_r   <= ENABLE_HOLD_RESET;
      power_up_wait_r <= POWER_UP_WAIT_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_FOUR_BIT_BUS:  four_bit_bus_r  <= cfg_data[0];
        CFG_ENABLE_HOLD:   enable_hold_r   <= cfg_data[7:0];
        CFG_POWER_UP_WAIT: power_up_wait_r <= cfg_data;
        default:           ;
      endcase
    end
  end

  // The byte being sent: a held command or data byte, the next initialisation command, or
  // the next decimal digit as an ASCII character.
  always_comb begin
    case (mode_r)
      MODE_INIT:   cur_byte = init_cmd(byte_cnt_r[1:0]);
      MODE_NUMBER: cur_byte = ASCII_ZERO | {4'h0, dig_digit};
      default:     cur_byte = byte_r;
    endcase
  end

  assign cur_rs    = (mode_r == MODE_DATA) || (mode_r == MODE_NUMBER);
  assign byte_done = ph_r && (!four_bit_bus_r || nib_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            MODE_INIT:   state_nxt = ST_WAIT;
            MODE_NUMBER: state_nxt = ST_CONV;
            default:     state_nxt = ST_BYTE;
          endcase
        end
      end
      ST_CONV: begin
        if (dig_stat.done) begin
          state_nxt = ST_BYTE;
        end
      end
      ST_WAIT: begin
        if (fire) begin
          state_nxt = four_bit_bus_r ? ST_WAKE : ST_BYTE;
        end
      end
      ST_WAKE: begin
        if (fire && ph_r) begin
          state_nxt = ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (fire && beat_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Pin state of the current beat and the counter updates.
  always_comb begin
    beat_rs      = cur_rs;
    beat_bus     = cur_byte;
    beat_en      = !ph_r;
    beat_hold    = ph_r ? 16'h0000 : {8'h00, enable_hold_r};
    beat_last    = 1'b0;
    byte_cnt_nxt = byte_cnt_r;
    nib_nxt      = nib_r;
    ph_nxt       = ph_r;
    case (state_r)
      ST_IDLE: begin
        nib_nxt = 1'b0;
        ph_nxt  = 1'b0;
        if (in_fire) begin
          byte_cnt_nxt = (in_mode == MODE_INIT) ? CNT_W'(3) : CNT_W'(1);
        end
      end
      ST_CONV: begin
        if (dig_stat.done) begin
          byte_cnt_nxt = dig_count;
        end
      end
      ST_WAIT: begin
        // The power-up wait is a single idle pin state with select, bus and enable low.
        beat_rs   = 1'b0;
        beat_bus  = 8'h00;
        beat_en   = 1'b0;
        beat_hold = power_up_wait_r;
      end
      ST_WAKE: begin
        beat_rs  = 1'b0;
        beat_bus = WAKE_NIBBLE;
        if (fire) begin
          ph_nxt = !ph_r;
        end
      end
      ST_BYTE: begin
        if (four_bit_bus_r) begin
          beat_bus = nib_r ? {cur_byte[3:0], 4'h0} : {cur_byte[7:4], 4'h0};
        end
        beat_last = byte_done && (byte_cnt_r == CNT_W'(1));
        if (fire) begin
          ph_nxt = !ph_r;
          if (ph_r) begin
            if (byte_done) begin
              nib_nxt      = 1'b0;
              byte_cnt_nxt = byte_cnt_r - 1'b1;
            end else begin
              nib_nxt = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      byte_cnt_r  <= '0;
      nib_r       <= 1'b0;
      ph_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      nib_r      <= nib_nxt;
      ph_r       <= ph_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request payload and the pin state register carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_mode;
      byte_r <= in_byte_value;
    end
    if (fire) begin
      out_reg_select_r   <= beat_rs;
      out_bus_value_r    <= beat_bus;
      out_enable_level_r <= beat_en;
      out_hold_units_r   <= beat_hold;
      out_last_r         <= beat_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_reg_select   = out_reg_select_r;
  assign out_read_write   = 1'b0;
  assign out_bus_value    = out_bus_value_r;
  assign out_enable_level = out_enable_level_r;
  assign out_hold_units   = out_hold_units_r;
  assign out_last         = out_last_r;

  a_idle_no_conv : assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !dig_stat.busy)
    else $error("request accepted while digit conversion is running");

  a_last_enable_low : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> !out_enable_level_r)
    else $error("final pin state of a run has enable high");

  a_byte_count : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BYTE) |-> (byte_cnt_r != '0))
    else $error("byte state entered with nothing left to send");

  a_pulse_hold : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_BYTE) && fire && !ph_r) |=>
      (out_enable_level_r && (out_hold_units_r == {8'h00, enable_hold_r})))
    else $error("enable pulse high state lost its hold time");

endmodule
